### rtl/core/arpc_pkg.sv
// shared types and constants for the arp cache with aging
package arpc_pkg;

  // default slot count handed to the top level
  localparam int ENTRIES_DEF = 16;
  // interfaces that may hold entries; a request on a higher index is refused
  localparam int IFACES = 4;
  // reset value of the timeout register
  localparam logic [15:0] TIMEOUT_RESET = 16'd15;

  // request commands
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_LOOKUP   = 3'd3;
  localparam logic [2:0] ST_TICK     = 3'd4;

  // one slot of the cache memory
  typedef struct packed {
    logic [31:0] ip;
    logic [1:0]  iface;
    logic [47:0] mac;
    logic [31:0] stamp;
  } slot_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic       scan_step;
    logic       live_only;
    logic       finish;
    logic       wr_en;
    logic       wr_sel_free;
    logic       tick;
    logic       res_hit;
    logic [2:0] res_status;
  } ctl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_last;
    logic iface_ok;
    logic match_found;
    logic free_found;
    logic out_busy;
  } dp_stat_t;

endpackage

### rtl/core/arpc_ram.sv
// generic single-write, single-read ram with registered read data
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/arpc_ctrl.sv
// controller state machine for the arp cache: accept, scan, drain, finish
module arpc_ctrl import arpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  dp_stat_t   stat,
  output ctl_cmd_t   ctl
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] op;
  logic [1:0] op_next;

  // take a request only while idle
  assign in_stall = (state != S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next    = state;
    op_next       = op;
    ctl           = '0;
    ctl.live_only = (op == CMD_LOOKUP);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          op_next  = command;
          unique case (command)
            CMD_ADD, CMD_LOOKUP: state_next = S_SCAN;
            CMD_TICK:            state_next = S_FINISH;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
          unique case (op)
            CMD_ADD: begin
              priority if (!stat.iface_ok) begin
                ctl.res_status = ST_FULL;
              end else if (stat.match_found) begin
                ctl.wr_en      = 1'b1;
                ctl.res_status = ST_UPDATED;
              end else if (stat.free_found) begin
                ctl.wr_en       = 1'b1;
                ctl.wr_sel_free = 1'b1;
                ctl.res_status  = ST_INSERTED;
              end else begin
                ctl.res_status = ST_FULL;
              end
            end
            CMD_LOOKUP: begin
              ctl.res_hit    = stat.match_found && stat.iface_ok;
              ctl.res_status = ST_LOOKUP;
            end
            default: begin
              ctl.tick       = 1'b1;
              ctl.res_status = ST_TICK;
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= CMD_ADD;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

endmodule

### rtl/core/arpc_dp.sv
// datapath of the arp cache: slot memory, valid bits, scan compare, result register
module arpc_dp import arpc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic [31:0] ip_addr,
  input  logic [1:0]  iface,
  input  logic [47:0] mac_in,
  input  ctl_cmd_t    ctl,
  output dp_stat_t    stat,
  input  logic        out_stall,
  output logic        out_valid,
  output logic        hit,
  output logic [47:0] mac_out,
  output logic [2:0]  status
);

  localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SW   = $bits(slot_t);

  logic [15:0]        timeout;
  logic [31:0]        now_seconds;
  logic [31:0]        req_ip;
  logic [1:0]         req_iface;
  logic [47:0]        req_mac;
  logic [IDXW-1:0]    rd_addr;
  logic               chk_vld;
  logic [IDXW-1:0]    chk_idx;
  logic [ENTRIES-1:0] slot_valid;
  logic               match_found;
  logic [IDXW-1:0]    match_idx;
  logic [47:0]        match_mac;
  logic               free_found;
  logic [IDXW-1:0]    free_idx;

  logic [SW-1:0]      rd_word;
  slot_t              rd_slot;
  slot_t              wr_slot;
  logic               wr_en;
  logic [IDXW-1:0]    wr_addr;
  logic               cur_valid;
  logic [31:0]        age;
  logic               stale;
  logic               key_eq;
  logic               is_match;
  logic               is_free;
  logic               clear_stale;

  // slot memory
  arpc_ram #(
    .WIDTH (SW),
    .DEPTH (ENTRIES),
    .AW    (IDXW)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_slot),
    .rd_en   (ctl.scan_step),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  // write side: refresh the matching slot or claim the free one
  assign wr_en         = ctl.finish && ctl.wr_en;
  assign wr_addr       = ctl.wr_sel_free ? free_idx : match_idx;
  assign wr_slot.ip    = req_ip;
  assign wr_slot.iface = req_iface;
  assign wr_slot.mac   = req_mac;
  assign wr_slot.stamp = now_seconds;

  // compare stage on the slot read in the previous cycle
  assign rd_slot     = slot_t'(rd_word);
  assign cur_valid   = slot_valid[chk_idx];
  assign age         = now_seconds - rd_slot.stamp;
  assign stale       = (age > {16'd0, timeout});
  assign key_eq      = (rd_slot.ip == req_ip) && (rd_slot.iface == req_iface);
  assign is_match    = chk_vld && cur_valid && key_eq && (!ctl.live_only || !stale);
  assign is_free     = chk_vld && (!cur_valid || stale);
  assign clear_stale = chk_vld && ctl.live_only && cur_valid && stale;

  // status toward the controller
  assign stat.scan_last   = (rd_addr == IDXW'(ENTRIES - 1));
  assign stat.iface_ok    = (32'(req_iface) < IFACES);
  assign stat.match_found = match_found;
  assign stat.free_found  = free_found;
  assign stat.out_busy    = out_valid && out_stall;

  // request fields and first-hit payloads
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_ip    <= ip_addr;
      req_iface <= iface;
      req_mac   <= mac_in;
    end
    chk_idx <= rd_addr;
    if (is_match && !match_found) begin
      match_idx <= chk_idx;
      match_mac <= rd_slot.mac;
    end
    if (is_free && !free_found) begin
      free_idx <= chk_idx;
    end
    if (ctl.finish) begin
      hit     <= ctl.res_hit;
      mac_out <= ctl.res_hit ? match_mac : 48'd0;
      status  <= ctl.res_status;
    end
  end

  // scan control, valid bits, clock and timeout
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout     <= TIMEOUT_RESET;
      now_seconds <= '0;
      rd_addr     <= '0;
      chk_vld     <= 1'b0;
      slot_valid  <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout <= cfg_wr_data;
      end
      if (ctl.finish && ctl.tick) begin
        now_seconds <= now_seconds + 32'd1;
      end
      if (ctl.load) begin
        rd_addr <= '0;
      end else if (ctl.scan_step) begin
        rd_addr <= rd_addr + IDXW'(1);
      end
      chk_vld <= ctl.scan_step;
      if (ctl.load) begin
        match_found <= 1'b0;
        free_found  <= 1'b0;
      end else begin
        if (is_match) begin
          match_found <= 1'b1;
        end
        if (is_free) begin
          free_found <= 1'b1;
        end
      end
      if (wr_en) begin
        slot_valid[wr_addr] <= 1'b1;
      end else if (clear_stale) begin
        slot_valid[chk_idx] <= 1'b0;
      end
      if (ctl.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a slot is written only when the scan found one
  a_write_has_slot: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (match_found || free_found))
    else $error("slot write without a found slot");

  // valid bits move only by an aging clear or a finishing write
  a_valid_stable: assert property (@(posedge clk) disable iff (rst)
    (!ctl.finish && !chk_vld) |=> $stable(slot_valid))
    else $error("valid bits changed outside scan or finish");

  // a hit is reported only with a recorded match
  a_hit_has_match: assert property (@(posedge clk) disable iff (rst)
    (ctl.finish && ctl.res_hit) |-> match_found)
    else $error("hit reported without a match");

  // a new result appears only after a finish command
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.finish))
    else $error("result appeared without finish");

endmodule

### rtl/core/arp_cache_with_aging_unit.sv
// IPv4-to-MAC cache with aging: ENTRIES slots keyed on address and interface.
// An add or lookup request scans every slot, one memory read per cycle, before
// it gives its result; a tick goes straight to the finish step, and a request
// with command 3 is taken and gives no result. The single read port of the
// slot memory is why the scan reads one slot at a time. One request is in work
// at a time; a finished result sits in an output register, so the next request
// is accepted while it waits, and the finish step waits only while that
// register is still full and stalled. Valid bits are cleared by reset at once,
// there is no clearing pass. The timeout register (reset 15 seconds) is
// written through cfg_wr_en and cfg_wr_data; the user must write it only while
// the block is idle, the block itself does not enforce this.
module arp_cache_with_aging_unit import arpc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [31:0] ip_addr,
  input  logic [1:0]  iface,
  input  logic [47:0] mac_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [47:0] mac_out,
  output logic [2:0]  status
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  // controller
  arpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .stat     (stat),
    .ctl      (ctl)
  );

  // datapath
  arpc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ip_addr     (ip_addr),
    .iface       (iface),
    .mac_in      (mac_in),
    .ctl         (ctl),
    .stat        (stat),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .hit         (hit),
    .mac_out     (mac_out),
    .status      (status)
  );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the arp cache with aging unit
module tb_top;
  import arpc_pkg::*;

  localparam int SLOTS = ENTRIES_DEF;
  localparam int KEY_POOL = 24;
  localparam int PHASE_ITEMS = 125;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  // the one command the block ignores
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] ip;
    logic [1:0]  ifc;
    logic [47:0] mac;
  } arp_req_t;

  typedef struct packed {
    logic        hit;
    logic [47:0] mac;
    logic [2:0]  status;
  } arp_reply_t;

  typedef struct {
    arp_req_t   req;
    bit         fixed;
    arp_reply_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = '0;
  logic [31:0] ip_addr = '0;
  logic [1:0]  iface = '0;
  logic [47:0] mac_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        hit;
  logic [47:0] mac_out;
  logic [2:0]  status;

  // cache image kept by the testbench
  bit          cache_valid [SLOTS];
  logic [31:0] cache_ip    [SLOTS];
  logic [1:0]  cache_iface [SLOTS];
  logic [47:0] cache_mac   [SLOTS];
  logic [31:0] cache_stamp [SLOTS];
  logic [31:0] clock_seconds = '0;
  logic [15:0] timeout_reg = TIMEOUT_RESET;

  arp_reply_t  pending_replies [$];
  dir_row_t    dir_rows [$];
  arp_req_t    key_pool [KEY_POOL];
  int          fail_count = 0;
  int          accepted_count = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;

  arp_cache_with_aging_unit uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .ip_addr     (ip_addr),
    .iface       (iface),
    .mac_in      (mac_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .mac_out     (mac_out),
    .status      (status)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // aging test on one slot, age taken modulo 2^32
  function automatic bit entry_stale(int k);
    logic [31:0] age;
    age = clock_seconds - cache_stamp[k];
    return age > {16'd0, timeout_reg};
  endfunction

  function automatic bit key_hit(int k, logic [31:0] ip, logic [1:0] ifc);
    return cache_valid[k] && cache_ip[k] == ip && cache_iface[k] == ifc;
  endfunction

  // apply one request to the cache image, returns 1 when a result is due
  function automatic bit predict_reply(input arp_req_t r, output arp_reply_t rep);
    bit done;
    rep = '0;
    done = 1'b0;
    case (r.command)
      CMD_ADD: begin
        rep.status = ST_FULL;
        if (int'(r.ifc) >= IFACES) return 1'b1;
        // refresh a matching key, stale or not
        for (int k = 0; k < SLOTS; k++) begin
          if (!done && key_hit(k, r.ip, r.ifc)) begin
            cache_mac[k] = r.mac;
            cache_stamp[k] = clock_seconds;
            rep.status = ST_UPDATED;
            done = 1'b1;
          end
        end
        // otherwise claim the lowest free or stale slot
        for (int k = 0; k < SLOTS; k++) begin
          if (!done && (!cache_valid[k] || entry_stale(k))) begin
            cache_valid[k] = 1'b1;
            cache_ip[k] = r.ip;
            cache_iface[k] = r.ifc;
            cache_mac[k] = r.mac;
            cache_stamp[k] = clock_seconds;
            rep.status = ST_INSERTED;
            done = 1'b1;
          end
        end
        return 1'b1;
      end
      CMD_LOOKUP: begin
        rep.status = ST_LOOKUP;
        // age out every stale entry first
        for (int k = 0; k < SLOTS; k++) begin
          if (cache_valid[k] && entry_stale(k)) cache_valid[k] = 1'b0;
        end
        if (int'(r.ifc) >= IFACES) return 1'b1;
        for (int k = 0; k < SLOTS; k++) begin
          if (!rep.hit && key_hit(k, r.ip, r.ifc)) begin
            rep.hit = 1'b1;
            rep.mac = cache_mac[k];
          end
        end
        return 1'b1;
      end
      CMD_TICK: begin
        clock_seconds = clock_seconds + 32'd1;
        rep.status = ST_TICK;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [47:0] random_mac();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[47:0];
  endfunction

  // mostly known keys so that updates, hits and a full table happen
  function automatic arp_req_t random_request();
    arp_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) r.command = CMD_ADD;
    else if (pick < 80) r.command = CMD_LOOKUP;
    else if (pick < 95) r.command = CMD_TICK;
    else r.command = CMD_NONE;
    if ($urandom_range(0, 4) != 0) begin
      pick = $urandom_range(0, KEY_POOL - 1);
      r.ip = key_pool[pick].ip;
      r.ifc = key_pool[pick].ifc;
    end else begin
      r.ip = $urandom;
      r.ifc = 2'($urandom_range(0, 3));
    end
    r.mac = random_mac();
    return r;
  endfunction

  function automatic void add_row(logic [1:0] cmd, logic [31:0] ip, logic [1:0] ifc,
                                  logic [47:0] mac, bit fixed, logic want_hit,
                                  logic [47:0] want_mac, logic [2:0] want_status);
    dir_row_t row;
    row.req = '{command: cmd, ip: ip, ifc: ifc, mac: mac};
    row.fixed = fixed;
    row.want = '{hit: want_hit, mac: want_mac, status: want_status};
    dir_rows.push_back(row);
  endfunction

  // offer one request, record its expected result, then idle as the burst says
  task automatic send_request(input arp_req_t r, input bit fixed, input arp_reply_t want,
                              input bit last);
    arp_reply_t rep;
    int gap;
    in_valid <= 1'b1;
    command <= r.command;
    ip_addr <= r.ip;
    iface <= r.ifc;
    mac_in <= r.mac;
    do @(posedge clk); while (in_stall);
    accepted_count++;
    if (predict_reply(r, rep)) pending_replies.push_back(fixed ? want : rep);
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(1, 5);
    end
    if (last || gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    timeout_reg = value;
  endtask

  task automatic report_failure(input string what, input arp_reply_t want,
                                input arp_reply_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s: expected hit=%0b mac=%h status=%0d, got hit=%0b mac=%h status=%0d",
               $realtime, what, want.hit, want.mac, want.status, got.hit, got.mac,
               got.status);
  endtask

  // result checker
  always @(posedge clk) begin : reply_check
    arp_reply_t got;
    arp_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{hit: hit, mac: mac_out, status: status};
      if (pending_replies.size() == 0) begin
        report_failure("result with no request pending", '0, got);
      end else begin
        want = pending_replies.pop_front();
        if (got.hit !== want.hit || got.mac !== want.mac || got.status !== want.status)
          report_failure("result mismatch", want, got);
      end
    end
  end

  // receiver stall pattern, with one long hold-off to back the block up
  initial begin : receiver
    int stall_mode;
    int mode_left;
    int cyc;
    bit hold_done;
    stall_mode = 0;
    mode_left = 0;
    cyc = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!hold_done && accepted_count >= 400) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (cyc % 4 != 0);
        endcase
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int phase2_at;
    int sent;
    bit last;
    arp_req_t r;
    logic [15:0] timeouts [8];

    for (int k = 0; k < KEY_POOL; k++) begin
      key_pool[k].ip = (k % 3 == 1) ? key_pool[k - 1].ip : $urandom;
      key_pool[k].ifc = 2'($urandom_range(0, 3));
    end
    timeouts = '{16'd0, 16'd1, 16'd3, 16'hFFFF, 16'd7, 16'd0, 16'd2, TIMEOUT_RESET};
    timeouts[5] = 16'($urandom_range(0, 40));

    // empty table, extremes of key and mac, update, tick, ignored command
    add_row(CMD_LOOKUP, 32'h0, 2'd0, 48'h0, 1, 1'b0, 48'h0, ST_LOOKUP);
    add_row(CMD_ADD, 32'h0, 2'd0, 48'h0, 1, 1'b0, 48'h0, ST_INSERTED);
    add_row(CMD_ADD, 32'hFFFF_FFFF, 2'd3, 48'hFFFF_FFFF_FFFF, 1, 1'b0, 48'h0, ST_INSERTED);
    add_row(CMD_LOOKUP, 32'hFFFF_FFFF, 2'd3, 48'h0, 1, 1'b1, 48'hFFFF_FFFF_FFFF, ST_LOOKUP);
    add_row(CMD_ADD, 32'h0, 2'd0, 48'h1234_5678_9ABC, 1, 1'b0, 48'h0, ST_UPDATED);
    add_row(CMD_LOOKUP, 32'h0, 2'd1, 48'h0, 1, 1'b0, 48'h0, ST_LOOKUP);
    add_row(CMD_TICK, 32'h0, 2'd0, 48'h0, 1, 1'b0, 48'h0, ST_TICK);
    add_row(CMD_NONE, 32'hDEAD_BEEF, 2'd2, 48'hFFFF_FFFF_FFFF, 0, 1'b0, 48'h0, ST_UPDATED);
    add_row(CMD_LOOKUP, 32'h0, 2'd0, 48'h0, 1, 1'b1, 48'h1234_5678_9ABC, ST_LOOKUP);
    // fill the rest of the table, then one more add finds it full
    for (int k = 2; k < SLOTS; k++)
      add_row(CMD_ADD, 32'h0A00_0000 + k, 2'(k % 4), random_mac(), 1, 1'b0, 48'h0,
              ST_INSERTED);
    add_row(CMD_ADD, 32'h0A00_00FF, 2'd2, random_mac(), 1, 1'b0, 48'h0, ST_FULL);
    add_row(CMD_LOOKUP, 32'h0A00_0005, 2'd1, 48'h0, 0, 1'b0, 48'h0, ST_LOOKUP);
    // timeout zero: the entries added before the tick are now stale
    phase2_at = dir_rows.size();
    add_row(CMD_ADD, 32'h0, 2'd0, 48'hFEDC_BA98_7654, 1, 1'b0, 48'h0, ST_UPDATED);
    add_row(CMD_ADD, 32'hC0A8_0001, 2'd1, random_mac(), 1, 1'b0, 48'h0, ST_INSERTED);
    add_row(CMD_LOOKUP, 32'h0A00_0005, 2'd1, 48'h0, 0, 1'b0, 48'h0, ST_LOOKUP);
    add_row(CMD_LOOKUP, 32'h0, 2'd0, 48'h0, 1, 1'b1, 48'hFEDC_BA98_7654, ST_LOOKUP);
    add_row(CMD_TICK, 32'h0, 2'd0, 48'h0, 1, 1'b0, 48'h0, ST_TICK);
    add_row(CMD_LOOKUP, 32'hC0A8_0001, 2'd1, 48'h0, 1, 1'b0, 48'h0, ST_LOOKUP);

    // reset
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[i]) begin
      if (i == phase2_at) begin
        drain_results();
        write_timeout(16'd0);
      end
      send_request(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].want,
                   i == phase2_at - 1 || i == dir_rows.size() - 1);
    end
    drain_results();

    // random phases, one timeout setting each
    for (int ph = 0; ph < 8; ph++) begin
      write_timeout(timeouts[ph]);
      gaps_on = (ph != 2 && ph != 5);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = random_request();
        if (r.command != CMD_NONE) sent++;
        last = (sent == PHASE_ITEMS);
        send_request(r, 1'b0, '0, last);
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
